/* design/vqre_pkg.sv */
// Package for the virtqueue request engine: sizes, codes, result and
// link-store request types. No dependencies.
`default_nettype none
package vqre_pkg;

	localparam int QUEUE_DEPTH = 128;
	localparam int AW = $clog2(QUEUE_DEPTH);   // descriptor number width
	localparam int LW = AW + 1;                // link width, holds QUEUE_DEPTH itself

	localparam logic [15:0] TIMEOUT_RESET = 16'd2000;
	localparam logic [2:0]  QLOG_RESET    = 3'd7;

	typedef enum logic [1:0] {
		MODE_SUBMIT = 2'd0,
		MODE_USED   = 2'd1,
		MODE_TICK   = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		KIND_DESC    = 3'd0,
		KIND_AVAIL   = 3'd1,
		KIND_AIDX    = 3'd2,
		KIND_NOTIFY  = 3'd3,
		KIND_DONE    = 3'd4,
		KIND_TIMEOUT = 3'd5,
		KIND_REJECT  = 3'd6
	} kind_t;

	typedef enum logic [1:0] {
		CFG_QLOG    = 2'd0,
		CFG_QNUM    = 2'd1,
		CFG_TIMEOUT = 2'd2
	} cfg_idx_t;

	localparam logic [1:0] FLAG_NEXT  = 2'd1;
	localparam logic [1:0] FLAG_WRITE = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_POP1,
		ST_POP2,
		ST_POP3,
		ST_AIDX,
		ST_NOTIFY,
		ST_REL1,
		ST_REL2
	} state_t;

	typedef struct packed {
		logic          valid;
		kind_t         kind;
		logic [6:0]    slot;
		logic [63:0]   buffer_address;
		logic [31:0]   length;
		logic [1:0]    desc_flags;
		logic [6:0]    next_slot;
		logic [15:0]   value;
		logic          last;
	} result_t;

	typedef struct packed {
		logic          re;
		logic [AW-1:0] raddr;
		logic          we;
		logic [AW-1:0] waddr;
		logic [LW-1:0] wdata;
	} link_req_t;

endpackage
`default_nettype wire

/* design/virtqueue_request_engine.sv */
// Top level of the virtqueue request engine: command sequencer and
// configuration registers. Depends on vqre_pkg, vqre_link_store.
//
// Usage:
//   Command channel: drive mode and its payload with start high; the item is
//   taken at a rising edge where start is high and busy is low.
//   Submit (mode 0) pops two descriptors off the free list and emits, one per
//   cycle, descriptor 0, descriptor 1, the avail entry, the avail index and a
//   notify. The first result is formed in ST_POP1 from the returned link and
//   registered onto the ports; busy stays high through ST_POP1 (second link
//   read through the registered read port of the link RAM), ST_POP2 and
//   ST_POP3 (chain link writes), ST_AIDX and ST_NOTIFY (avail index, notify).
//   A used element or tick that ends the request emits one result the cycle
//   after accept and then holds busy through ST_REL1 and ST_REL2 while both
//   descriptors are pushed back (one RAM write each). Other used elements,
//   ticks, rejects and notifies leave the engine idle.
//   Results: each result is on the result ports for exactly one cycle with
//   result_valid high; last marks the final result of an item. The receiver
//   cannot stall, so nothing is held.
//   Config: cfg_ready is always high; write only while idle.
//   Reset: arst_n clears all control state; the free list reads as the
//   setup chain (entry i links to i plus one) with no clearing pass.
`default_nettype none
module virtqueue_request_engine (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// command channel
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  mode,
	input  wire logic [63:0] out_address,
	input  wire logic [31:0] out_length,
	input  wire logic [63:0] in_address,
	input  wire logic [31:0] in_length,
	input  wire logic [31:0] used_id,
	input  wire logic [31:0] used_length,
	// configuration channel
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	// result channel
	output logic             result_valid,
	output logic [2:0]       kind,
	output logic [6:0]       slot,
	output logic [63:0]      buffer_address,
	output logic [31:0]      length,
	output logic [1:0]       desc_flags,
	output logic [6:0]       next_slot,
	output logic [15:0]      value,
	output logic             last
);

	localparam int AW = vqre_pkg::AW;
	localparam int LW = vqre_pkg::LW;

	vqre_pkg::state_t    state_q, state_d;
	vqre_pkg::result_t   res_q, res_d;
	vqre_pkg::link_req_t link_req;
	logic [LW-1:0]       link_rdata;

	// configuration registers
	logic [2:0]  qlog_q;
	logic [15:0] qnum_q;
	logic [15:0] tmo_q;

	// queue state
	logic [AW-1:0] free_head_q, free_head_d;
	logic [15:0]   avail_index_q, avail_index_d;
	logic          pending_q, pending_d;
	logic [AW-1:0] head_q, head_d;
	logic [AW-1:0] second_q, second_d;
	logic [15:0]   elapsed_q, elapsed_d;
	logic [AW-1:0] d0_q, d0_d;
	logic [AW-1:0] d1_q, d1_d;

	// submit payload, held for the descriptor writes
	logic [63:0] out_addr_q, in_addr_q;
	logic [31:0] out_len_q, in_len_q;

	logic          accept;
	logic [2:0]    qlog_eff;
	logic [AW:0]   size_one;
	logic [AW-1:0] mask;
	logic [AW-1:0] link_m;
	logic [AW-1:0] rel_head, rel_second;

	assign busy      = (state_q != vqre_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	// Ring size is 2^log2 (log2 of zero acts as one), capped at the depth
	assign qlog_eff = (qlog_q == 3'd0) ? 3'd1 : qlog_q;
	assign size_one = (AW+1)'(1) << qlog_eff;
	assign mask     = (int'(qlog_eff) >= AW) ? '1 : (size_one[AW-1:0] - AW'(1));

	assign link_m     = link_rdata[AW-1:0] & mask;
	assign rel_head   = head_q & mask;
	assign rel_second = second_q & mask;

	vqre_link_store u_links (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (link_req),
		.rdata (link_rdata)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qlog_q <= vqre_pkg::QLOG_RESET;
			qnum_q <= '0;
			tmo_q  <= vqre_pkg::TIMEOUT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				vqre_pkg::CFG_QLOG:    qlog_q <= cfg_data[2:0];
				vqre_pkg::CFG_QNUM:    qnum_q <= cfg_data;
				vqre_pkg::CFG_TIMEOUT: tmo_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// latch submit payload on accept
	always_ff @(posedge clk) begin
		if (accept) begin
			out_addr_q <= out_address;
			out_len_q  <= out_length;
			in_addr_q  <= in_address;
			in_len_q   <= in_length;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= vqre_pkg::ST_IDLE;
			res_q         <= '0;
			free_head_q   <= '0;
			avail_index_q <= '0;
			pending_q     <= 1'b0;
			head_q        <= '0;
			second_q      <= '0;
			elapsed_q     <= '0;
			d0_q          <= '0;
			d1_q          <= '0;
		end else begin
			state_q       <= state_d;
			res_q         <= res_d;
			free_head_q   <= free_head_d;
			avail_index_q <= avail_index_d;
			pending_q     <= pending_d;
			head_q        <= head_d;
			second_q      <= second_d;
			elapsed_q     <= elapsed_d;
			d0_q          <= d0_d;
			d1_q          <= d1_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		res_d         = '0;
		link_req      = '0;
		free_head_d   = free_head_q;
		avail_index_d = avail_index_q;
		pending_d     = pending_q;
		head_d        = head_q;
		second_d      = second_q;
		elapsed_d     = elapsed_q;
		d0_d          = d0_q;
		d1_d          = d1_q;

		unique case (state_q)
			vqre_pkg::ST_IDLE: begin
				if (accept) begin
					case (mode)
						vqre_pkg::MODE_SUBMIT: begin
							if (pending_q) begin
								res_d.valid = 1'b1;
								res_d.kind  = vqre_pkg::KIND_REJECT;
								res_d.last  = 1'b1;
							end else begin
								// read the link of the first free descriptor
								d0_d           = free_head_q & mask;
								link_req.re    = 1'b1;
								link_req.raddr = free_head_q & mask;
								state_d        = vqre_pkg::ST_POP1;
							end
						end
						vqre_pkg::MODE_USED: begin
							if (pending_q && (used_id == 32'(head_q))) begin
								res_d.valid  = 1'b1;
								res_d.kind   = vqre_pkg::KIND_DONE;
								res_d.slot   = 7'(head_q);
								res_d.length = used_length;
								res_d.last   = 1'b1;
								state_d      = vqre_pkg::ST_REL1;
							end
						end
						vqre_pkg::MODE_TICK: begin
							if (pending_q) begin
								res_d.valid = 1'b1;
								res_d.last  = 1'b1;
								if (elapsed_q >= tmo_q) begin
									res_d.kind = vqre_pkg::KIND_TIMEOUT;
									res_d.slot = 7'(head_q);
									state_d    = vqre_pkg::ST_REL1;
								end else begin
									elapsed_d   = elapsed_q + 16'd1;
									res_d.kind  = vqre_pkg::KIND_NOTIFY;
									res_d.value = qnum_q;
								end
							end
						end
						default: ;
					endcase
				end
			end
			vqre_pkg::ST_POP1: begin
				// second descriptor arrives; read its link, write descriptor 0
				d1_d                 = link_m;
				link_req.re          = 1'b1;
				link_req.raddr       = link_m;
				res_d.valid          = 1'b1;
				res_d.kind           = vqre_pkg::KIND_DESC;
				res_d.slot           = 7'(d0_q);
				res_d.buffer_address = out_addr_q;
				res_d.length         = out_len_q;
				res_d.desc_flags     = vqre_pkg::FLAG_NEXT;
				res_d.next_slot      = 7'(link_m);
				state_d              = vqre_pkg::ST_POP2;
			end
			vqre_pkg::ST_POP2: begin
				// advance free head past the pair, chain d0 to d1
				free_head_d          = link_m;
				link_req.we          = 1'b1;
				link_req.waddr       = d0_q;
				link_req.wdata       = LW'(d1_q);
				res_d.valid          = 1'b1;
				res_d.kind           = vqre_pkg::KIND_DESC;
				res_d.slot           = 7'(d1_q);
				res_d.buffer_address = in_addr_q;
				res_d.length         = in_len_q;
				res_d.desc_flags     = vqre_pkg::FLAG_WRITE;
				state_d              = vqre_pkg::ST_POP3;
			end
			vqre_pkg::ST_POP3: begin
				link_req.we    = 1'b1;
				link_req.waddr = d1_q;
				link_req.wdata = '0;
				res_d.valid    = 1'b1;
				res_d.kind     = vqre_pkg::KIND_AVAIL;
				res_d.slot     = 7'(avail_index_q[AW-1:0] & mask);
				res_d.value    = 16'(d0_q);
				avail_index_d  = avail_index_q + 16'd1;
				pending_d      = 1'b1;
				head_d         = d0_q;
				second_d       = d1_q;
				elapsed_d      = '0;
				state_d        = vqre_pkg::ST_AIDX;
			end
			vqre_pkg::ST_AIDX: begin
				res_d.valid = 1'b1;
				res_d.kind  = vqre_pkg::KIND_AIDX;
				res_d.value = avail_index_q;
				state_d     = vqre_pkg::ST_NOTIFY;
			end
			vqre_pkg::ST_NOTIFY: begin
				res_d.valid = 1'b1;
				res_d.kind  = vqre_pkg::KIND_NOTIFY;
				res_d.value = qnum_q;
				res_d.last  = 1'b1;
				state_d     = vqre_pkg::ST_IDLE;
			end
			vqre_pkg::ST_REL1: begin
				// push the second descriptor in front of the free list
				link_req.we    = 1'b1;
				link_req.waddr = rel_second;
				link_req.wdata = LW'(free_head_q);
				state_d        = vqre_pkg::ST_REL2;
			end
			vqre_pkg::ST_REL2: begin
				link_req.we    = 1'b1;
				link_req.waddr = rel_head;
				link_req.wdata = LW'(rel_second);
				free_head_d    = rel_head;
				pending_d      = 1'b0;
				state_d        = vqre_pkg::ST_IDLE;
			end
			default: begin
				state_d = vqre_pkg::ST_IDLE;
			end
		endcase
	end

	assign result_valid   = res_q.valid;
	assign kind           = res_q.kind;
	assign slot           = res_q.slot;
	assign buffer_address = res_q.buffer_address;
	assign length         = res_q.length;
	assign desc_flags     = res_q.desc_flags;
	assign next_slot      = res_q.next_slot;
	assign value          = res_q.value;
	assign last           = res_q.last;

endmodule
`default_nettype wire

/* design/vqre_ram.sv */
// Generic simple dual-port RAM with registered read.
// No dependencies.
`default_nettype none
module vqre_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

/* design/vqre_link_store.sv */
// Free-list link store: RAM plus per-entry valid bits so that an entry never
// written reads as its reset link (index plus one). Depends on vqre_pkg, vqre_ram.
`default_nettype none
module vqre_link_store (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire vqre_pkg::link_req_t         req,
	output logic      [vqre_pkg::LW-1:0]     rdata
);

	logic [vqre_pkg::QUEUE_DEPTH-1:0] valid_q;
	logic [vqre_pkg::AW-1:0]          raddr_s1;
	logic                             vld_s1;
	logic [vqre_pkg::LW-1:0]          ram_rdata;

	vqre_ram #(
		.WIDTH(vqre_pkg::LW),
		.DEPTH(vqre_pkg::QUEUE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (req.we),
		.waddr(req.waddr),
		.wdata(req.wdata),
		.re   (req.re),
		.raddr(req.raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (req.we) begin
			valid_q[req.waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.re) begin
			raddr_s1 <= req.raddr;
			vld_s1   <= valid_q[req.raddr];
		end
	end

	// Substitute the reset link for entries not yet written
	assign rdata = vld_s1 ? ram_rdata : ({1'b0, raddr_s1} + vqre_pkg::LW'(1));

endmodule
`default_nettype wire

/* sim/tb_virtqueue_request_engine.sv */
`timescale 1ns / 100ps
// Self-checking bench for virtqueue_request_engine: directed table, then random
// traffic in three throttling phases. Depends on vqre_pkg and the engine RTL.

module tb_virtqueue_request_engine;
	import vqre_pkg::*;

	// Mode code with no meaning; the engine must drop it silently.
	localparam logic [1:0] MODE_NONE = 2'd3;
	// Register index beyond the three real ones; writes to it change nothing.
	localparam logic [1:0] CFG_SPARE = 2'd3;
	localparam logic [63:0] ONES64 = '1;
	localparam logic [31:0] ONES32 = '1;
	localparam int MAX_REPORTS = 10;

	typedef enum logic {ROW_CMD, ROW_CFG} row_op_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [63:0] out_address;
		logic [31:0] out_length;
		logic [63:0] in_address;
		logic [31:0] in_length;
		logic [31:0] used_id;
		logic [31:0] used_length;
	} vq_cmd_t;

	// Field order matches the result ports so a concatenation of them fills it.
	typedef struct packed {
		kind_t       kind;
		logic [6:0]  slot;
		logic [63:0] addr;
		logic [31:0] len;
		logic [1:0]  flags;
		logic [6:0]  nxt;
		logic [15:0] val;
		logic        last;
	} vq_result_t;

	typedef struct packed {
		row_op_t     op;
		vq_cmd_t     cmd;
		logic        typed;      // expectation written into the row itself
		kind_t       t_kind;
		logic [6:0]  t_slot;
		logic [31:0] t_len;
		logic [15:0] t_val;
		logic [15:0] q_cfg;      // register values for a programming row
		logic [15:0] n_cfg;
		logic [15:0] t_cfg;
	} plan_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  mode;
	logic [63:0] out_address;
	logic [31:0] out_length;
	logic [63:0] in_address;
	logic [31:0] in_length;
	logic [31:0] used_id;
	logic [31:0] used_length;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        result_valid;
	logic [2:0]  kind;
	logic [6:0]  slot;
	logic [63:0] buffer_address;
	logic [31:0] length;
	logic [1:0]  desc_flags;
	logic [6:0]  next_slot;
	logic [15:0] value;
	logic        last;

	virtqueue_request_engine DUT (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Predictor state: a private copy of the driver-side queue bookkeeping
	// ------------------------------------------------------------------
	logic [2:0]  qlog_r;
	logic [15:0] qnum_r;
	logic [15:0] tmo_r;
	logic [7:0]  link_of [QUEUE_DEPTH];
	logic [7:0]  free_head_p;
	logic [15:0] avail_idx_p;
	logic [15:0] used_count_p;
	logic        req_open;
	logic [7:0]  open_head;
	logic [7:0]  open_second;
	logic [15:0] ticks_elapsed;

	// Expected engine outputs, oldest first.
	vq_result_t ring_ops_due [$];

	int errors;
	int items_sent;
	int results_seen;
	int dones_seen;
	int timeouts_seen;
	int rejects_seen;

	vq_result_t got;
	vq_result_t want;

	// Ring size in use: a log2 of zero counts as one, and the size never
	// exceeds the physical depth.
	function automatic int unsigned ring_size();
		int unsigned l;
		int unsigned s;
		l = qlog_r;
		if (l == 0) begin
			l = 1;
		end
		s = 1 << l;
		return (s > QUEUE_DEPTH) ? QUEUE_DEPTH : s;
	endfunction

	function automatic vq_result_t mk_res(kind_t k, int unsigned s, logic [63:0] a,
			logic [31:0] len, logic [1:0] f, int unsigned n, logic [15:0] v, logic l);
		vq_result_t r;
		r.kind  = k;
		r.slot  = 7'(s);
		r.addr  = a;
		r.len   = len;
		r.flags = f;
		r.nxt   = 7'(n);
		r.val   = v;
		r.last  = l;
		return r;
	endfunction

	// Push both descriptors of the finished chain back onto the free list.
	function automatic void release_chain();
		int unsigned s;
		int unsigned h;
		int unsigned d;
		s = ring_size();
		h = open_head % s;
		d = open_second % s;
		link_of[d]  = free_head_p;
		link_of[h]  = 8'(d);
		free_head_p = 8'(h);
		req_open    = 1'b0;
	endfunction

	// Advance the queue bookkeeping by one accepted item and list what the
	// engine must emit for it.
	task automatic step_virtqueue(input vq_cmd_t c, ref vq_result_t res[$]);
		int unsigned s;
		int unsigned d0;
		int unsigned d1;
		int unsigned h;
		s = ring_size();
		res.delete();
		case (c.mode)
		MODE_SUBMIT: begin
			if (req_open) begin
				res.push_back(mk_res(KIND_REJECT, 0, '0, '0, '0, 0, '0, 1'b1));
			end else begin
				// pop two linked descriptors, then build the chain
				d0 = free_head_p % s;
				d1 = link_of[d0] % s;
				free_head_p = 8'(link_of[d1] % s);
				link_of[d0] = 8'(d1);
				link_of[d1] = '0;
				res.push_back(mk_res(KIND_DESC, d0, c.out_address, c.out_length,
					FLAG_NEXT, d1, '0, 1'b0));
				res.push_back(mk_res(KIND_DESC, d1, c.in_address, c.in_length,
					FLAG_WRITE, 0, '0, 1'b0));
				res.push_back(mk_res(KIND_AVAIL, avail_idx_p % s, '0, '0, '0, 0,
					16'(d0), 1'b0));
				avail_idx_p = avail_idx_p + 16'd1;
				res.push_back(mk_res(KIND_AIDX, 0, '0, '0, '0, 0, avail_idx_p, 1'b0));
				res.push_back(mk_res(KIND_NOTIFY, 0, '0, '0, '0, 0, qnum_r, 1'b1));
				open_head     = 8'(d0);
				open_second   = 8'(d1);
				ticks_elapsed = '0;
				req_open      = 1'b1;
			end
		end
		MODE_USED: begin
			used_count_p = used_count_p + 16'd1;
			// the whole 32-bit id must match, not just its low bits
			if (req_open && c.used_id == {24'd0, open_head}) begin
				h = open_head;
				release_chain();
				res.push_back(mk_res(KIND_DONE, h, '0, c.used_length, '0, 0, '0, 1'b1));
			end
		end
		MODE_TICK: begin
			if (req_open) begin
				if (ticks_elapsed >= tmo_r) begin
					h = open_head;
					release_chain();
					res.push_back(mk_res(KIND_TIMEOUT, h, '0, '0, '0, 0, '0, 1'b1));
				end else begin
					ticks_elapsed = ticks_elapsed + 16'd1;
					res.push_back(mk_res(KIND_NOTIFY, 0, '0, '0, '0, 0, qnum_r, 1'b1));
				end
			end
		end
		default: ;
		endcase
	endtask

	// ------------------------------------------------------------------
	// Result checking
	// ------------------------------------------------------------------
	function automatic string show(vq_result_t r);
		return $sformatf("kind=%0d slot=%0d addr=%h len=%h flags=%0d next=%0d val=%h last=%0b",
			r.kind, r.slot, r.addr, r.len, r.flags, r.nxt, r.val, r.last);
	endfunction

	task automatic flag_fail(input string msg);
		errors++;
		if (errors <= MAX_REPORTS) begin
			$display("[%0t] MISMATCH %s", $realtime, msg);
		end
	endtask

	// Results cannot be held off: sample every strobed cycle at the edge that ends it.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && result_valid === 1'b1) begin
			got = {kind, slot, buffer_address, length, desc_flags, next_slot, value, last};
			if (ring_ops_due.size() == 0) begin
				flag_fail($sformatf("unexpected result: %s", show(got)));
			end else begin
				want = ring_ops_due.pop_front();
				if (got !== want) begin
					flag_fail($sformatf("\n  expected %s\n  actual   %s", show(want), show(got)));
				end
				results_seen++;
				case (want.kind)
				KIND_DONE:    dones_seen++;
				KIND_TIMEOUT: timeouts_seen++;
				KIND_REJECT:  rejects_seen++;
				default: ;
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------

	// Present one item and hold it until the engine takes it, then predict.
	// Returns the number of results it causes.
	task automatic issue(input vq_cmd_t c, input logic typed, input vq_result_t typed_res,
			output int n);
		vq_result_t res [$];
		start       <= 1'b1;
		mode        <= c.mode;
		out_address <= c.out_address;
		out_length  <= c.out_length;
		in_address  <= c.in_address;
		in_length   <= c.in_length;
		used_id     <= c.used_id;
		used_length <= c.used_length;
		@(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
		step_virtqueue(c, res);
		n = res.size();
		items_sent++;
		if (typed) begin
			ring_ops_due.push_back(typed_res);
		end else begin
			foreach (res[i]) begin
				ring_ops_due.push_back(res[i]);
			end
		end
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		case (idx)
		CFG_QLOG:    qlog_r = data[2:0];
		CFG_QNUM:    qnum_r = data;
		CFG_TIMEOUT: tmo_r  = data;
		default: ;
		endcase
	endtask

	task automatic program_queue(input logic [15:0] q, input logic [15:0] n,
			input logic [15:0] t);
		write_reg(CFG_QLOG, q);
		write_reg(CFG_QNUM, n);
		write_reg(CFG_TIMEOUT, t);
		write_reg(CFG_SPARE, 16'($urandom));
		cfg_valid <= 1'b0;
	endtask

	// Bring the engine to rest: close any open request with its own id, drain
	// every expected result, then wait out the descriptor push-back.
	task automatic quiesce();
		vq_cmd_t c;
		int n;
		if (req_open) begin
			c = '0;
			c.mode        = MODE_USED;
			c.used_id     = {24'd0, open_head};
			c.used_length = $urandom;
			issue(c, 1'b0, '0, n);
		end
		start <= 1'b0;
		while (ring_ops_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
	endtask

	// Random traffic: mostly well-formed request lifetimes (submit, some
	// ticks, completion or timeout), with stray used elements, rejected
	// submits and dead mode codes mixed in.
	task automatic random_phase(input int idle_pct, input int target);
		vq_cmd_t c;
		int counted;
		int pick;
		int n;
		counted = 0;
		while (counted < target) begin
			while ($urandom_range(99) < idle_pct) begin
				start <= 1'b0;
				@(posedge clk);
			end
			pick = $urandom_range(99);
			c.out_address = {$urandom, $urandom};
			c.out_length  = $urandom;
			c.in_address  = {$urandom, $urandom};
			c.in_length   = $urandom;
			c.used_id     = $urandom;
			c.used_length = $urandom;
			if (req_open) begin
				if (pick < 40) begin
					c.mode = MODE_TICK;
				end else if (pick < 75) begin
					c.mode    = MODE_USED;
					c.used_id = {24'd0, open_head};
				end else if (pick < 87) begin
					// stray element: sometimes a plausible descriptor number
					c.mode = MODE_USED;
					if (pick < 81) begin
						c.used_id = $urandom_range(QUEUE_DEPTH - 1);
					end
				end else if (pick < 96) begin
					c.mode = MODE_SUBMIT;
				end else begin
					c.mode = MODE_NONE;
				end
			end else begin
				if (pick < 75) begin
					c.mode = MODE_SUBMIT;
				end else if (pick < 85) begin
					c.mode = MODE_USED;
				end else if (pick < 93) begin
					c.mode = MODE_TICK;
				end else begin
					c.mode = MODE_NONE;
				end
			end
			issue(c, 1'b0, '0, n);
			if (n > 0 || c.mode == MODE_USED) begin
				counted++;
			end
		end
	endtask

	// Table row builders
	function automatic plan_row_t submit_row(logic [63:0] oa, logic [31:0] ol,
			logic [63:0] ia, logic [31:0] il);
		plan_row_t r;
		r = '0;
		r.cmd.mode        = MODE_SUBMIT;
		r.cmd.out_address = oa;
		r.cmd.out_length  = ol;
		r.cmd.in_address  = ia;
		r.cmd.in_length   = il;
		return r;
	endfunction

	function automatic plan_row_t used_row(logic [31:0] id, logic [31:0] len);
		plan_row_t r;
		r = '0;
		r.cmd.mode        = MODE_USED;
		r.cmd.used_id     = id;
		r.cmd.used_length = len;
		return r;
	endfunction

	function automatic plan_row_t bare_row(logic [1:0] m);
		plan_row_t r;
		r = '0;
		r.cmd.mode = m;
		return r;
	endfunction

	function automatic plan_row_t expecting(plan_row_t r, kind_t k, int unsigned s,
			logic [31:0] len, int unsigned v);
		r.typed  = 1'b1;
		r.t_kind = k;
		r.t_slot = 7'(s);
		r.t_len  = len;
		r.t_val  = 16'(v);
		return r;
	endfunction

	function automatic plan_row_t cfg_row(logic [15:0] q, logic [15:0] n, logic [15:0] t);
		plan_row_t r;
		r = '0;
		r.op    = ROW_CFG;
		r.q_cfg = q;
		r.n_cfg = n;
		r.t_cfg = t;
		return r;
	endfunction

	plan_row_t plan [$];

	initial begin
		int n;
		arst_n      <= 1'b0;
		start       <= 1'b0;
		mode        <= MODE_SUBMIT;
		out_address <= '0;
		out_length  <= '0;
		in_address  <= '0;
		in_length   <= '0;
		used_id     <= '0;
		used_length <= '0;
		cfg_valid   <= 1'b0;
		cfg_index   <= CFG_QLOG;
		cfg_data    <= '0;

		// predictor starts from the setup chain: entry i links to i plus one
		qlog_r = QLOG_RESET;
		qnum_r = '0;
		tmo_r  = TIMEOUT_RESET;
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			link_of[i] = 8'(i + 1);
		end
		free_head_p   = '0;
		avail_idx_p   = '0;
		used_count_p  = '0;
		req_open      = 1'b0;
		open_head     = '0;
		open_second   = '0;
		ticks_elapsed = '0;

		// Directed part, first under reset register values.
		plan.push_back(used_row(32'd0, 32'd0));                 // used element while idle
		plan.push_back(bare_row(MODE_TICK));                    // tick while idle
		plan.push_back(bare_row(MODE_NONE));                    // dead mode code
		plan.push_back(submit_row(ONES64, ONES32, '0, '0));
		plan.push_back(expecting(submit_row('0, '0, '0, '0), KIND_REJECT, 0, 0, 0));
		plan.push_back(expecting(bare_row(MODE_TICK), KIND_NOTIFY, 0, 0, 0));
		plan.push_back(used_row(32'd5, ONES32));                // another id
		plan.push_back(used_row(32'h0000_0100, ONES32));        // head id plus high bits
		plan.push_back(expecting(used_row(32'd0, ONES32), KIND_DONE, 0, ONES32, 0));
		plan.push_back(submit_row('0, '0, ONES64, ONES32));
		plan.push_back(expecting(used_row(32'd0, 32'd0), KIND_DONE, 0, 0, 0));
		// size register zero (ring of two), widest notify value, zero timeout
		plan.push_back(cfg_row(16'd0, 16'hFFFF, 16'd0));
		plan.push_back(submit_row(64'hA5A5_A5A5_A5A5_A5A5, 32'h5A5A_5A5A,
			64'h5A5A_5A5A_5A5A_5A5A, 32'hA5A5_A5A5));
		plan.push_back(expecting(bare_row(MODE_TICK), KIND_TIMEOUT, 0, 0, 0));
		plan.push_back(bare_row(MODE_TICK));
		plan.push_back(submit_row(64'h0123_4567_89AB_CDEF, 32'h0000_0001,
			64'hFEDC_BA98_7654_3210, 32'h8000_0000));
		plan.push_back(expecting(submit_row(ONES64, ONES32, ONES64, ONES32),
			KIND_REJECT, 0, 0, 0));
		plan.push_back(expecting(used_row(32'd0, 32'h1234_5678), KIND_DONE, 0,
			32'h1234_5678, 0));
		// full ring with junk in the spare register bits, one-tick timeout
		plan.push_back(cfg_row(16'hFFFF, 16'd1, 16'd1));
		plan.push_back(submit_row(64'h8000_0000_0000_0001, 32'h7FFF_FFFF,
			64'h7FFF_FFFF_FFFF_FFFE, 32'h0000_FFFF));
		plan.push_back(expecting(bare_row(MODE_TICK), KIND_NOTIFY, 0, 0, 1));
		plan.push_back(bare_row(MODE_TICK));
		plan.push_back(submit_row('0, ONES32, ONES64, '0));
		plan.push_back(used_row(ONES32, ONES32));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].op == ROW_CFG) begin
				quiesce();
				program_queue(plan[i].q_cfg, plan[i].n_cfg, plan[i].t_cfg);
			end else begin
				issue(plan[i].cmd, plan[i].typed,
					mk_res(plan[i].t_kind, plan[i].t_slot, '0, plan[i].t_len, '0, 0,
						plan[i].t_val, 1'b1), n);
			end
		end

		// Phase one: ring of four, short random timeouts, sender idles a third.
		quiesce();
		program_queue(16'd2, 16'($urandom), 16'($urandom_range(3)));
		random_phase(33, 70);

		// Phase two: smallest ring, longest timeout, sender mostly idle.
		quiesce();
		program_queue(16'd1, 16'd0, 16'hFFFF);
		random_phase(84, 70);

		// Phase three: mid-size ring, back-to-back items.
		quiesce();
		program_queue({13'($urandom), 3'($urandom_range(6, 3))}, 16'($urandom), 16'd2);
		random_phase(0, 70);

		quiesce();

		$display("sent %0d items over ring sizes 2 to 128; checked %0d results",
			items_sent, results_seen);
		$display("  of them %0d completions, %0d timeouts, %0d rejected submits",
			dones_seen, timeouts_seen, rejects_seen);
		if (errors == 0) begin
			$display("virtqueue_request_engine regression: pass");
		end else begin
			$display("%0d mismatches", errors);
			$display("virtqueue_request_engine regression: fail");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#3_000_000;
		$display("timeout with %0d results outstanding", ring_ops_due.size());
		$display("virtqueue_request_engine regression: fail");
		$finish;
	end

endmodule
